// ===== hdl/snrt_pkg.sv =====
// ----------------------------------------------------------------------------
// snrt_pkg
// shared types and constants for the sorted nonce replay table
// ----------------------------------------------------------------------------
`default_nettype none

package snrt_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int VAL_W       = 64;
    localparam int TIME_W      = 32;
    localparam int CNT_OUT_W   = 7;
    localparam logic [TIME_W-1:0] STALE_RST = 32'd60;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_PURGE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CMP,
        OP_INS,
        OP_PRG
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_PRG,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] ctime;
    } t_cell_data;

    typedef struct packed {
        t_cell_op          op;
        logic [VAL_W-1:0]  nonce;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] stale_time;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/sorted_nonce_replay_table.sv =====
// ----------------------------------------------------------------------------
// sorted_nonce_replay_table
// sorted table of nonces with creation times, built as a chain of cells
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry command, nonce and current time;
// a transaction completes on a clock edge with valid high and stall low.
// output channel: o_out_valid / i_out_stall carry one result per transaction.
// stale_time is written through i_cfg_we / i_cfg_data while the block is
// idle; the user must keep to this, the block itself does not enforce it.
// store and find run S_CMP, where every cell compares against the nonce,
// S_UPD, where the chain shifts to insert, and S_OUT, which loads the output
// register. purge runs S_CMP, then S_PRG until no stale entry is left, then
// S_OUT; the chain drops one stale entry per cycle by shifting everything
// above it down one cell. no new transaction is taken while one is in
// progress; unstalled, the next accept coincides with the output load.
// reset empties the table and sets stale_time to 60.
// a stalled result holds in the output register; the block can accept one
// more transaction and then waits before loading its result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_nonce_replay_table
    import snrt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [TIME_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_command,
    input  wire logic [VAL_W-1:0]     i_nonce_value,
    input  wire logic [TIME_W-1:0]    i_now_time,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_status,
    output logic [TIME_W-1:0]         o_entry_time,
    output logic [VAL_W-1:0]          o_newest_value,
    output logic [VAL_W-1:0]          o_oldest_value,
    output logic [CNT_OUT_W-1:0]      o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [VAL_W-1:0]  r_nonce;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_stale;
    logic [CW-1:0]     r_count;
    t_status           r_status;
    logic [TIME_W-1:0] r_etime;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [TIME_W-1:0] r_out_time;
    logic [VAL_W-1:0]  r_out_newest;
    logic [VAL_W-1:0]  r_out_oldest;
    logic [CW-1:0]     r_out_count;

    t_cell_ctl         w_ctl;
    t_cell_op          w_op;
    logic              w_take_in;
    logic              w_out_free;
    logic              w_load_out;
    logic              w_full;
    logic              w_store_ok;
    logic              w_any_del;
    logic              w_hit_any;
    logic [TIME_W-1:0] w_ins_time;
    logic [TIME_W-1:0] w_hit_time;
    logic [VAL_W-1:0]  w_newest;
    logic [DEPTH-1:0]  w_valid_vec;

    t_cell_data        w_data     [DEPTH];
    t_cell_data        w_prev     [DEPTH];
    t_cell_data        w_next     [DEPTH];
    logic              w_lt       [DEPTH];
    logic              w_eq       [DEPTH];
    logic              w_del      [DEPTH];
    logic              w_del_upto [DEPTH];
    logic              w_prev_lt  [DEPTH];
    logic              w_prev_eq  [DEPTH];
    logic              w_prev_du  [DEPTH];
    logic              w_next_del [DEPTH];
    logic              w_hit      [DEPTH];
    logic [TIME_W-1:0] w_cins     [DEPTH];
    logic [TIME_W-1:0] w_chit     [DEPTH];
    logic [VAL_W-1:0]  w_clast    [DEPTH];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_take_in  = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_store_ok = !w_full && ((r_count == '0) || w_lt[0]);
    assign w_any_del  = w_del_upto[DEPTH-1];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take_in) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = (r_cmd == CMD_PURGE) ? S_PRG : S_UPD;
            end
            S_UPD: begin
                n_state = S_OUT;
            end
            S_PRG: begin
                if (!w_any_del) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = w_take_in ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_load_out = 1'b0;
        w_op       = OP_HOLD;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_CMP: begin
                w_op = OP_CMP;
            end
            S_UPD: begin
                if (r_cmd == CMD_STORE && w_store_ok) w_op = OP_INS;
            end
            S_PRG: begin
                w_op = OP_PRG;
            end
            S_OUT: begin
                o_in_stall = !w_out_free;
                w_load_out = w_out_free;
            end
            default: begin
            end
        endcase
    end

    assign w_ctl.op         = w_op;
    assign w_ctl.nonce      = r_nonce;
    assign w_ctl.now        = r_now;
    assign w_ctl.stale_time = r_stale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stale     <= STALE_RST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_stale <= i_cfg_data;
            if (w_op == OP_INS) begin
                r_count <= r_count + CW'(1);
            end else if (w_op == OP_PRG && w_any_del) begin
                r_count <= r_count - CW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_cmd   <= t_cmd'(i_command);
            r_nonce <= i_nonce_value;
            r_now   <= i_now_time;
        end
        if (r_state == S_CMP) begin
            r_status <= ST_OK;
            r_etime  <= '0;
        end else if (r_state == S_UPD) begin
            case (r_cmd)
                CMD_STORE: begin
                    if (w_full) begin
                        r_status <= ST_FULL;
                        r_etime  <= '0;
                    end else if (w_store_ok) begin
                        r_status <= ST_OK;
                        r_etime  <= w_ins_time;
                    end else begin
                        r_status <= ST_MISS;
                        r_etime  <= '0;
                    end
                end
                CMD_FIND: begin
                    r_status <= w_hit_any ? ST_OK : ST_MISS;
                    r_etime  <= w_hit_time;
                end
                default: begin
                    r_status <= ST_MISS;
                    r_etime  <= '0;
                end
            endcase
        end
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_time   <= r_etime;
            r_out_newest <= w_newest;
            r_out_oldest <= w_data[0].valid ? w_data[0].value : '0;
            r_out_count  <= r_count;
        end
    end

    // cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_prev[gi]    = '0;
            assign w_prev_lt[gi] = 1'b1;
            assign w_prev_eq[gi] = 1'b0;
            assign w_prev_du[gi] = 1'b0;
        end else begin : g_mid_prev
            assign w_prev[gi]    = w_data[gi-1];
            assign w_prev_lt[gi] = w_lt[gi-1];
            assign w_prev_eq[gi] = w_eq[gi-1];
            assign w_prev_du[gi] = w_del_upto[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_next[gi]     = '0;
            assign w_next_del[gi] = 1'b0;
        end else begin : g_mid_next
            assign w_next[gi]     = w_data[gi+1];
            assign w_next_del[gi] = w_del[gi+1];
        end

        snrt_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_prev          (w_prev[gi]),
            .i_prev_lt       (w_prev_lt[gi]),
            .i_prev_eq       (w_prev_eq[gi]),
            .i_prev_del_upto (w_prev_du[gi]),
            .i_next          (w_next[gi]),
            .i_next_del      (w_next_del[gi]),
            .o_data          (w_data[gi]),
            .o_lt            (w_lt[gi]),
            .o_eq            (w_eq[gi]),
            .o_del           (w_del[gi]),
            .o_del_upto      (w_del_upto[gi]),
            .o_hit           (w_hit[gi]),
            .o_ins_time      (w_cins[gi]),
            .o_hit_time      (w_chit[gi]),
            .o_last_value    (w_clast[gi])
        );

        assign w_valid_vec[gi] = w_data[gi].valid;
    end

    // one-hot collection across the chain
    always_comb begin
        w_hit_any  = 1'b0;
        w_ins_time = '0;
        w_hit_time = '0;
        w_newest   = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_hit_any  = w_hit_any | w_hit[k];
            w_ins_time = w_ins_time | w_cins[k];
            w_hit_time = w_hit_time | w_chit[k];
            w_newest   = w_newest | w_clast[k];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_entry_time   = r_out_time;
    assign o_newest_value = r_out_newest;
    assign o_oldest_value = r_out_oldest;
    assign o_entry_count  = CNT_OUT_W'(r_out_count);

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("entry count differs from occupied cells");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_INS) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not add one entry");

    a_purge_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRG) |=> (r_count <= $past(r_count)))
        else $error("purge grew the table");

    a_purge_keeps_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRG && r_count != '0) |=> (r_count != '0))
        else $error("purge emptied a non-empty table");

endmodule

`default_nettype wire

// ===== hdl/snrt_cell.sv =====
// ----------------------------------------------------------------------------
// snrt_cell
// one slot of the sorted chain: holds an entry, compares, inserts and compacts
// ----------------------------------------------------------------------------
`default_nettype none

module snrt_cell
    import snrt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire t_cell_data        i_prev,
    input  wire logic              i_prev_lt,
    input  wire logic              i_prev_eq,
    input  wire logic              i_prev_del_upto,
    input  wire t_cell_data        i_next,
    input  wire logic              i_next_del,
    output t_cell_data             o_data,
    output logic                   o_lt,
    output logic                   o_eq,
    output logic                   o_del,
    output logic                   o_del_upto,
    output logic                   o_hit,
    output logic [TIME_W-1:0]      o_ins_time,
    output logic [TIME_W-1:0]      o_hit_time,
    output logic [VAL_W-1:0]       o_last_value
);

    logic              r_valid;
    logic [VAL_W-1:0]  r_value;
    logic [TIME_W-1:0] r_ctime;
    logic              r_lt;
    logic              r_eq;
    logic              r_del;

    logic              w_ins;
    logic [TIME_W-1:0] w_new_time;
    logic [TIME_W-1:0] w_age;
    logic              w_stale;

    assign w_ins      = !r_lt && i_prev_lt;
    assign w_new_time = r_valid ? i_prev.ctime : i_ctl.now;
    assign w_age      = i_ctl.now - r_ctime;
    assign w_stale    = (i_ctl.now >= r_ctime) && (w_age >= i_ctl.stale_time);

    // control: valid bit and compare flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
            r_del   <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_CMP: begin
                    r_lt  <= r_valid && (r_value < i_ctl.nonce);
                    r_eq  <= r_valid && (r_value == i_ctl.nonce);
                    r_del <= r_valid && i_next.valid && w_stale;
                end
                OP_INS: begin
                    if (!r_lt) begin
                        r_valid <= w_ins ? 1'b1 : i_prev.valid;
                    end
                end
                OP_PRG: begin
                    if (o_del_upto) begin
                        r_valid <= i_next.valid;
                        r_del   <= i_next_del;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_INS: begin
                if (!r_lt) begin
                    if (w_ins) begin
                        r_value <= i_ctl.nonce;
                        r_ctime <= w_new_time;
                    end else begin
                        r_value <= i_prev.value;
                        r_ctime <= i_prev.ctime;
                    end
                end
            end
            OP_PRG: begin
                if (o_del_upto) begin
                    r_value <= i_next.value;
                    r_ctime <= i_next.ctime;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_data.valid  = r_valid;
    assign o_data.value  = r_value;
    assign o_data.ctime  = r_ctime;
    assign o_lt          = r_lt;
    assign o_eq          = r_eq;
    assign o_del         = r_del;
    assign o_del_upto    = r_del || i_prev_del_upto;
    assign o_hit         = r_eq && !i_prev_eq;
    assign o_hit_time    = o_hit ? r_ctime : '0;
    assign o_ins_time    = w_ins ? w_new_time : '0;
    assign o_last_value  = (r_valid && !i_next.valid) ? r_value : '0;

endmodule

`default_nettype wire
